// File: rtl/core/sipd_pkg.sv
package sipd_pkg;

	// ASCII codes emitted by the converter
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_BLANK = 7'h20;

	// Configuration register indexes
	localparam logic [0:0] REG_TEXT_WIDTH = 1'b0;
	localparam logic [0:0] REG_PAD_ZERO   = 1'b1;

	// Width of the configuration write data (widest register)
	localparam int unsigned CFG_DATA_W = 7;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_LEN  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

endpackage

// File: rtl/core/signed_int_to_padded_decimal.sv
// Signed integer to padded decimal ASCII text.
//
// Input channel (in_valid/in_ready, value): one signed two's complement
// number per beat. in_ready is high only while the converter is idle.
// Output channel (out_valid/out_ready, char_out, last): one ASCII character
// per beat, most significant first, with last high on the final character.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = text_width, 1 = pad_zero) at the clock edge; write only while idle.
//
// Steps per item: take the beat, run the shift-and-add-3 binary to BCD
// loop, size the text, then emit one character per cycle while out_ready
// is high. No new item is taken until the final character is loaded into
// the single output register; a new item is taken while that final
// character still waits in the output register.
// A stalled receiver holds the output register and the emit sequence.
// Reset (arst_n low) returns to idle, drops out_valid and clears
// text_width and pad_zero to zero.
module signed_int_to_padded_decimal
	import sipd_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned MAX_CHARS  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [6:0]                   char_out,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	// Decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
	localparam int unsigned ND    = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int unsigned BCD_W = 4 * ND;
	localparam int unsigned DW    = $clog2(ND + 1);
	localparam int unsigned IW    = $clog2(ND);
	localparam int unsigned BW    = $clog2(VALUE_BITS);
	localparam int unsigned LW    = $clog2(MAX_CHARS + ND + 2);

	state_t                  state_q;
	logic [6:0]              text_width_q;
	logic                    pad_zero_q;
	logic                    neg_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [BW-1:0]           bit_cnt_q;
	logic [IW-1:0]           dig_idx_q;
	logic [LW-1:0]           total_q;
	logic [LW-1:0]           pad_q;
	logic [LW-1:0]           k_q;
	logic                    out_valid_q;
	logic [6:0]              char_q;
	logic                    last_q;

	logic [BCD_W-1:0]        bcd_adj;
	logic [DW-1:0]           ndig_c;
	logic [6:0]              fw_clip;
	logic [LW-1:0]           fw_c;
	logic [LW-1:0]           textlen_c;
	logic [LW-1:0]           total_c;
	logic [LW-1:0]           pad_c;
	logic [LW-1:0]           neg_w;
	logic [6:0]              char_c;
	logic                    digit_c;
	logic                    last_c;
	logic                    load_out;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;

	// Add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Count significant digits (at least one for zero)
	always_comb begin
		ndig_c = DW'(1);
		for (int i = 1; i < ND; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				ndig_c = DW'(i + 1);
			end
		end
	end

	// Size the text: width clipped, total capped, pad count
	always_comb begin
		fw_clip   = (text_width_q > 7'(MAX_CHARS)) ? 7'(MAX_CHARS) : text_width_q;
		fw_c      = LW'(fw_clip);
		textlen_c = LW'(ndig_c) + LW'(neg_q);
		total_c   = (textlen_c > fw_c) ? textlen_c : fw_c;
		if (total_c > LW'(MAX_CHARS)) begin
			total_c = LW'(MAX_CHARS);
		end
		pad_c = (total_c > textlen_c) ? (total_c - textlen_c) : '0;
	end

	// Pick the character at position k_q
	always_comb begin
		neg_w   = LW'(neg_q);
		char_c  = CH_ZERO + {3'd0, bcd_q[4*dig_idx_q +: 4]};
		digit_c = 1'b0;
		if (!pad_zero_q) begin
			if (k_q < pad_q) begin
				char_c = CH_BLANK;
			end else if (neg_q && (k_q == pad_q)) begin
				char_c = CH_MINUS;
			end else begin
				digit_c = 1'b1;
			end
		end else begin
			if (neg_q && (k_q == '0)) begin
				char_c = CH_MINUS;
			end else if (k_q < (pad_q + neg_w)) begin
				char_c = CH_ZERO;
			end else begin
				digit_c = 1'b1;
			end
		end
		last_c = (k_q == (total_q - LW'(1)));
	end

	assign load_out = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_width_q <= '0;
			pad_zero_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_WIDTH: text_width_q <= cfg_data[6:0];
				REG_PAD_ZERO:   pad_zero_q   <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Sequencer: take a beat, convert, size, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (bit_cnt_q == '0) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load_out && last_c) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the conversion
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					neg_q     <= value[VALUE_BITS-1];
					mag_q     <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
					bcd_q     <= '0;
					bit_cnt_q <= BW'(VALUE_BITS - 1);
				end
			end
			S_CONV: begin
				bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
				mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BW'(1);
			end
			S_LEN: begin
				total_q   <= total_c;
				pad_q     <= pad_c;
				dig_idx_q <= IW'(ndig_c - DW'(1));
				k_q       <= '0;
			end
			S_EMIT: begin
				if (load_out) begin
					k_q <= k_q + LW'(1);
					if (digit_c) begin
						dig_idx_q <= dig_idx_q - IW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Output register: load on a free slot, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= char_c;
			last_q <= last_c;
		end
	end

endmodule

// File: sim/tb.sv
module tb
	import sipd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHARS   = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_TAIL  = 40;
	localparam int SEGMENTS    = 8;
	localparam int SEG_ITEMS   = 55;

	// One expected output character
	typedef struct packed {
		logic [6:0] code;
		logic       is_last;
	} text_char_t;

	// Directed row: field settings (raw write data), number, and its text where obvious
	typedef struct {
		logic [6:0]  fw_data;
		logic [6:0]  pz_data;
		logic [31:0] num;
		string       text;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	dir_row_t dir_rows[DIR_ROWS] = '{
		'{7'd0,   7'd0,   32'd0,          "0"},
		'{7'd0,   7'd0,   32'h7FFFFFFF,   "2147483647"},
		'{7'd0,   7'd0,   32'h80000000,   "-2147483648"},
		'{7'd0,   7'd0,   32'hFFFFFFFF,   "-1"},
		'{7'd0,   7'd0,   32'd1,          "1"},
		'{7'd0,   7'd0,   32'd9,          "9"},
		'{7'd0,   7'd0,   32'd10,         "10"},
		'{7'd0,   7'd0,   32'hC4653600,   "-1000000000"},
		'{7'd0,   7'd0,   32'h12345678,   ""},
		'{7'd5,   7'd0,   32'hFFFFFFD6,   "  -42"},
		'{7'd5,   7'd0,   32'd7,          "    7"},
		'{7'd5,   7'd1,   32'hFFFFFFD6,   "-0042"},
		'{7'd5,   7'd1,   32'd0,          "00000"},
		'{7'd11,  7'd1,   32'h80000000,   "-2147483648"},
		'{7'd3,   7'd1,   32'd123456,     "123456"},
		'{7'd64,  7'd0,   32'h80000000,   ""},
		'{7'd64,  7'd1,   32'h7FFFFFFF,   ""},
		'{7'd127, 7'd1,   32'hFFFFFFFF,   ""},
		'{7'd100, 7'd0,   32'd5,          ""},
		'{7'd12,  7'h7E,  32'hFFFFFFF9,   ""},
		'{7'd12,  7'h7F,  32'hFFFFFFF9,   ""},
		'{7'd1,   7'd0,   32'h55555555,   ""},
		'{7'd2,   7'd1,   32'hAAAAAAAA,   ""}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [6:0]            char_out;
	logic                  last;
	logic                  cfg_we = 1'b0;
	logic [0:0]            cfg_index = REG_TEXT_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	text_char_t  pending_chars[$];
	logic [6:0]  width_reg = 7'd0;
	logic        pad_zero_reg = 1'b0;
	logic [6:0]  cur_fw_data = 7'd0;
	logic [6:0]  cur_pz_data = 7'd0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;

	signed_int_to_padded_decimal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Append one number's characters, marking the final one
	function automatic void queue_text(input logic [6:0] codes[$]);
		text_char_t tc;
		foreach (codes[i]) begin
			tc.code    = codes[i];
			tc.is_last = (i == codes.size() - 1);
			pending_chars.push_back(tc);
		end
	endfunction

	// Decimal text of one number under the current width and pad settings
	function automatic void predict_text(input logic [31:0] num);
		logic        neg;
		logic [31:0] mag;
		logic [3:0]  digs[$];
		logic [6:0]  codes[$];
		int          width, total, pad;
		neg = num[31];
		mag = neg ? ~num + 32'd1 : num;
		do begin
			digs.push_front(4'(mag % 32'd10));
			mag = mag / 32'd10;
		end while (mag != 32'd0);
		width = (int'(width_reg) > MAX_CHARS) ? MAX_CHARS : int'(width_reg);
		total = digs.size() + int'(neg);
		if (width > total)
			total = width;
		if (total > MAX_CHARS)
			total = MAX_CHARS;
		pad = total - digs.size() - int'(neg);
		if (!pad_zero_reg)
			repeat (pad) codes.push_back(CH_BLANK);
		if (neg)
			codes.push_back(CH_MINUS);
		if (pad_zero_reg)
			repeat (pad) codes.push_back(CH_ZERO);
		foreach (digs[i])
			codes.push_back(CH_ZERO + {3'b000, digs[i]});
		queue_text(codes);
	endfunction

	// Expected text given literally
	function automatic void queue_literal(input string txt);
		logic [6:0] codes[$];
		byte        c;
		for (int i = 0; i < txt.len(); i++) begin
			c = txt[i];
			codes.push_back(c[6:0]);
		end
		queue_text(codes);
	endfunction

	// Random number, weighted toward digit-count boundaries and extremes
	function automatic logic [31:0] pick_value();
		logic [31:0] pick;
		logic [31:0] p;
		int unsigned k;
		p = 32'd1;
		k = $urandom_range(9);
		case ($urandom_range(5))
			0, 1: pick = $urandom;
			2: pick = 32'(int'($urandom_range(40)) - 20);
			3: begin
				repeat (k) p = p * 32'd10;
				if ($urandom_range(1))
					p = p - 32'd1;
				pick = $urandom_range(1) ? p : ~p + 32'd1;
			end
			4: begin
				case ($urandom_range(3))
					0: pick = 32'h80000000;
					1: pick = 32'h7FFFFFFF;
					2: pick = 32'd0;
					default: pick = 32'hFFFFFFFF;
				endcase
			end
			default: begin
				p = $urandom >> $urandom_range(31);
				pick = $urandom_range(1) ? p : ~p + 32'd1;
			end
		endcase
		return pick;
	endfunction

	function automatic void report_fault(input string what, input logic [7:0] want,
			input logic [7:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch on %0s at %0t: expected %h, got %h", what, $time, want, got);
	endfunction

	// Offer one number; record its expected text when the beat is taken
	task automatic offer_value(input logic [31:0] num, input string txt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= num;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (txt == "")
			predict_text(num);
		else
			queue_literal(txt);
	endtask

	// Stop offering and wait for every outstanding character
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers back to back while idle
	task automatic set_fields(input logic [6:0] fw_data, input logic [6:0] pz_data);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TEXT_WIDTH;
		cfg_data  <= fw_data;
		@(posedge clk);
		cfg_index <= REG_PAD_ZERO;
		cfg_data  <= pz_data;
		@(posedge clk);
		cfg_we       <= 1'b0;
		width_reg    = fw_data;
		pad_zero_reg = pz_data[0];
		cur_fw_data  = fw_data;
		cur_pz_data  = pz_data;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
			default: begin send_idle_pct = 20; recv_stall_pct = 20; end
		endcase
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each output beat against the oldest expected character
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				report_fault("unexpected beat", 8'h00, {char_out, last});
			end else begin
				want = pending_chars.pop_front();
				if (char_out !== want.code)
					report_fault("char_out", {1'b0, want.code}, {1'b0, char_out});
				if (last !== want.is_last)
					report_fault("last", {7'd0, want.is_last}, {7'd0, last});
			end
		end
	end

	// Watchdog: give up after a long stretch with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [6:0] fw_pick, pz_pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: reset settings first, then extremes and pad modes
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].fw_data != cur_fw_data || dir_rows[r].pz_data != cur_pz_data) begin
				drain_outputs();
				set_fields(dir_rows[r].fw_data, dir_rows[r].pz_data);
			end
			offer_value(dir_rows[r].num, dir_rows[r].text);
		end

		// Random segments, each with its own settings and one of four idling patterns
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_outputs();
			fw_pick = 7'($urandom_range(127));
			pz_pick = 7'($urandom_range(127));
			case (seg)
				0: begin fw_pick = 7'd0;   pz_pick = 7'd0; end
				1: begin fw_pick = 7'd127; pz_pick = 7'd1; end
				2: fw_pick = 7'd64;
				4: begin fw_pick = 7'd11;  pz_pick = 7'd1; end
				5: fw_pick = 7'($urandom_range(20));
				6: begin fw_pick = 7'd63;  pz_pick = 7'd0; end
				default: ;
			endcase
			set_fields(fw_pick, pz_pick);
			set_idling(seg % 4);
			// long receiver hold-off while the sender keeps offering
			if (seg % 4 == 0)
				hold_req <= ~hold_req;
			repeat (SEG_ITEMS) offer_value(pick_value(), "");
		end

		drain_outputs();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (error_count == 0 && pending_chars.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
